>>> rtl/core/crrm_pkg.sv
// ----------------------------------------------------------------------------
// crrm_pkg: shared types and constants of the cascaded range remap block
// Holds item field widths, default sizes, function codes and link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package crrm_pkg;

   localparam int STAGES_DEF  = 7;
   localparam int ENTRIES_DEF = 64;
   localparam int VAL_W       = 32;
   localparam int LOAD_IDX_W  = 8;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_XLATE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Value handed from one stage cell to the next.
   typedef struct packed {
      logic             vld;
      logic [VAL_W-1:0] value;
   } link_type;

   // Table write and clear command seen by one stage cell.
   typedef struct packed {
      logic                  we;
      logic                  clr;
      logic [LOAD_IDX_W-1:0] idx;
      logic [VAL_W-1:0]      dest;
      logic [VAL_W-1:0]      src;
      logic [VAL_W-1:0]      span;
   } load_type;

endpackage

`default_nettype wire

>>> rtl/core/crrm_cell.sv
// ----------------------------------------------------------------------------
// crrm_cell: one remap stage
// Owns the range table of one stage and scans it one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crrm_cell
   import crrm_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire load_type ld,
   input  wire link_type lnk_in,
   output link_type      lnk_out
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [VAL_W-1:0] mem_dest [ENTRIES];
   logic [VAL_W-1:0] mem_src  [ENTRIES];
   logic [VAL_W-1:0] mem_span [ENTRIES];

   state_type        state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             chk_ff, chk_in;
   logic             last_ff, last_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] rd_dest_ff, rd_src_ff, rd_span_ff;
   logic             rd_vld_ff;
   link_type         out_ff, out_in;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             hit, done;
   logic [VAL_W:0]   hi_bound;

   assign rd_addr = addr_ff[IDX_W-1:0];
   assign wr_addr = ld.idx[IDX_W-1:0];

   // Table storage: written by load items, read once per scan cycle.
   always_ff @(posedge clock) begin
      if (ld.we) begin
         mem_dest[wr_addr] <= ld.dest;
         mem_src[wr_addr]  <= ld.src;
         mem_span[wr_addr] <= ld.span;
      end
      rd_dest_ff <= mem_dest[rd_addr];
      rd_src_ff  <= mem_src[rd_addr];
      rd_span_ff <= mem_span[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   // The upper bound is compared unwrapped, one bit wider than the data.
   assign hi_bound = {1'b0, rd_src_ff} + {1'b0, rd_span_ff};
   assign hit      = rd_vld_ff && (value_ff >= rd_src_ff) && ({1'b0, value_ff} < hi_bound);
   assign done     = (state_ff == ST_SCAN) && chk_ff && (hit || last_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      chk_in       = 1'b0;
      last_in      = last_ff;
      value_in     = value_ff;
      out_in.vld   = 1'b0;
      out_in.value = out_ff.value;
      case (state_ff)
         ST_IDLE: begin
            if (lnk_in.vld) begin
               value_in = lnk_in.value;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (done) begin
               out_in.vld   = 1'b1;
               out_in.value = hit ? (rd_dest_ff + (value_ff - rd_src_ff)) : value_ff;
               state_in     = ST_IDLE;
            end else if (addr_ff < CNT_W'(ENTRIES)) begin
               chk_in  = 1'b1;
               last_in = (addr_ff == CNT_W'(ENTRIES - 1));
               addr_in = addr_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         chk_ff     <= 1'b0;
         out_ff.vld <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         out_ff.vld   <= out_in.vld;
         out_ff.value <= out_in.value;
         if (ld.clr) begin
            valid_ff <= '0;
         end else if (ld.we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      last_ff      <= last_in;
      value_ff     <= value_in;
   end

   assign lnk_out = out_ff;

   a_done_only_scan: assert property (@(posedge clock) disable iff (reset)
      out_ff.vld |-> $past(state_ff == ST_SCAN))
      else $error("cell result without a scan");
   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !lnk_in.vld)
      else $error("cell received a value while scanning");
   a_chk_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_in |-> (addr_ff < CNT_W'(ENTRIES)))
      else $error("cell scan ran past its table");

endmodule

`default_nettype wire

>>> rtl/core/cascaded_range_remap_min.sv
// ----------------------------------------------------------------------------
// cascaded_range_remap_min: cascaded interval offset remap with running minimum
// Load, translate and clear items on a stream port; one result item each.
// ----------------------------------------------------------------------------
// A load or clear item's result is registered and shown in the cycle after
// acceptance. A translate item passes through the stage cells in order, each
// reading its table one entry per cycle and stopping at the first matching
// range. One item is in work at a time.
// Reset clears all valid bits, the minimum and the handshake state; table
// contents are undefined until loaded and need no clearing pass.
`default_nettype none

module cascaded_range_remap_min
   import crrm_pkg::*;
#(
   parameter int STAGES  = STAGES_DEF,
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // func[1:0], stage[4:2], entry[10:5], dest_base[42:11], src_base[74:43],
   // span[106:75], seed[138:107], zero fill [143:139]
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // location[31:0], min_location[63:32], min_valid[64], zero fill [71:65]
   output logic [71:0]       rsp_tdata
);

   logic [1:0]       f_func;
   logic [2:0]       f_stage;
   logic [5:0]       f_entry;
   logic             accept, load_ok, done;
   logic             busy_ff, busy_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [VAL_W-1:0] rsp_loc_ff, rsp_loc_in;
   logic [VAL_W-1:0] min_ff, min_in;
   logic             seen_ff, seen_in;
   link_type         start_ff, start_in;
   link_type         lnk [STAGES+1];

   assign f_func  = req_tdata[1:0];
   assign f_stage = req_tdata[4:2];
   assign f_entry = req_tdata[10:5];

   // Take a new item only when no translate is running and the result slot
   // is free or being emptied in this cycle.
   assign req_tready = !busy_ff && (!rsp_vld_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign load_ok    = (32'(f_stage) < 32'(STAGES)) && (32'(f_entry) < 32'(ENTRIES));

   assign lnk[0] = start_ff;
   assign done   = lnk[STAGES].vld;

   // Load and clear commands reach every cell; only the addressed stage writes.
   for (genvar s = 0; s < STAGES; s++) begin : g_cell
      load_type ld;
      assign ld.we   = accept && (f_func == FUNC_LOAD) && load_ok && (32'(f_stage) == s);
      assign ld.clr  = accept && (f_func == FUNC_CLEAR);
      assign ld.idx  = LOAD_IDX_W'(f_entry);
      assign ld.dest = req_tdata[42:11];
      assign ld.src  = req_tdata[74:43];
      assign ld.span = req_tdata[106:75];

      crrm_cell #(
         .ENTRIES(ENTRIES)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ld     (ld),
         .lnk_in (lnk[s]),
         .lnk_out(lnk[s+1])
      );
   end

   always_comb begin
      busy_in        = busy_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_tready;
      rsp_loc_in     = rsp_loc_ff;
      min_in         = min_ff;
      seen_in        = seen_ff;
      start_in.vld   = 1'b0;
      start_in.value = req_tdata[138:107];
      if (accept) begin
         case (f_func)
            FUNC_XLATE: begin
               start_in.vld = 1'b1;
               busy_in      = 1'b1;
            end
            FUNC_CLEAR: begin
               min_in     = '1;
               seen_in    = 1'b0;
               rsp_vld_in = 1'b1;
               rsp_loc_in = '0;
            end
            default: begin
               rsp_vld_in = 1'b1;
               rsp_loc_in = '0;
            end
         endcase
      end
      // The final stage hands back the translated value.
      if (done) begin
         busy_in    = 1'b0;
         rsp_vld_in = 1'b1;
         rsp_loc_in = lnk[STAGES].value;
         seen_in    = 1'b1;
         if (lnk[STAGES].value < min_ff) begin
            min_in = lnk[STAGES].value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         min_ff       <= '1;
         seen_ff      <= 1'b0;
         start_ff.vld <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         rsp_vld_ff     <= rsp_vld_in;
         min_ff         <= min_in;
         seen_ff        <= seen_in;
         start_ff.vld   <= start_in.vld;
         start_ff.value <= start_in.value;
      end
   end

   always_ff @(posedge clock) begin
      rsp_loc_ff     <= rsp_loc_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, seen_ff, min_ff, rsp_loc_ff};

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !rsp_vld_ff)
      else $error("result pending during a translate");
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("chain finished with no translate running");
   a_min_reset_value: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (min_ff == '1))
      else $error("minimum set while no value seen");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !busy_ff)
      else $error("item taken during a translate");

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cascaded range remap block
// Loads remap ranges, translates values through every stage and clears the
// table, predicting location and running minimum for each item and comparing
// every result item in order, with random idling and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import crrm_pkg::*;

   localparam int NST = STAGES_DEF;
   localparam int NEN = ENTRIES_DEF;
   localparam int NSLOT = NST * NEN;
   localparam int EXP_DEPTH = 64;

   // One expected result item, laid out as the result data from the top bit.
   typedef struct packed {
      logic        min_valid;
      logic [31:0] min_location;
      logic [31:0] location;
   } remap_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // func[1:0], stage[4:2], entry[10:5], dest_base[42:11], src_base[74:43],
   // span[106:75], seed[138:107], zero fill [143:139]
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // location[31:0], min_location[63:32], min_valid[64], zero fill [71:65]
   logic [71:0]  rsp_tdata;

   cascaded_range_remap_min u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the remap table and the running minimum.
   logic [31:0] shadow_dest [NSLOT];
   logic [31:0] shadow_src  [NSLOT];
   logic [31:0] shadow_span [NSLOT];
   logic        shadow_vld  [NSLOT];
   logic [31:0] shadow_min;
   logic        shadow_seen;

   // Expected result items in order, kept as a ring with running counters.
   remap_result_type exp_ring [EXP_DEPTH];
   int          exp_wr;
   int          exp_rd;
   int          mismatch_count;
   bit          failed;
   bit          idle_enable;   // random idling on both sides when set
   bit          rsp_hold;      // long receiver hold-off request

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tb NOT OK");
      $finish;
   end

   // Walks one value through every stage; first valid matching slot wins.
   function automatic logic [31:0] remap_value(input logic [31:0] seed);
      logic [31:0] v;
      logic [32:0] hi;
      int          k;
      bit          hit;
      v = seed;
      for (int st = 0; st < NST; st++) begin
         hit = 1'b0;
         for (int e = 0; e < NEN && !hit; e++) begin
            k = st * NEN + e;
            hi = {1'b0, shadow_src[k]} + {1'b0, shadow_span[k]};
            if (shadow_vld[k] && v >= shadow_src[k] && {1'b0, v} < hi) begin
               v = shadow_dest[k] + (v - shadow_src[k]);
               hit = 1'b1;
            end
         end
      end
      return v;
   endfunction

   // Updates the shadow state for one accepted item and queues its result.
   task automatic predict_item(input logic [143:0] d);
      logic [1:0]       func;
      int               k;
      remap_result_type r;
      func = d[1:0];
      r.location = '0;
      if (func == FUNC_LOAD) begin
         if (d[4:2] < NST) begin
            k = int'(d[4:2]) * NEN + int'(d[10:5]);
            shadow_dest[k] = d[42:11];
            shadow_src[k]  = d[74:43];
            shadow_span[k] = d[106:75];
            shadow_vld[k]  = 1'b1;
         end
      end else if (func == FUNC_XLATE) begin
         r.location = remap_value(d[138:107]);
         if (r.location < shadow_min) shadow_min = r.location;
         shadow_seen = 1'b1;
      end else if (func == FUNC_CLEAR) begin
         for (int i = 0; i < NSLOT; i++) shadow_vld[i] = 1'b0;
         shadow_min = '1;
         shadow_seen = 1'b0;
      end
      r.min_location = shadow_min;
      r.min_valid = shadow_seen;
      exp_ring[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endtask

   // Offers one item, with an optional random gap first, and waits for it
   // to be accepted. Called right after a falling edge; leaves the item on
   // the bus, so the next call or the caller takes it down.
   task automatic send_item(input logic [143:0] d);
      if (idle_enable) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_item(d);
      @(negedge clock);
   endtask

   function automatic logic [143:0] pack_item(input logic [1:0] func,
         input logic [2:0] st, input logic [5:0] en, input logic [31:0] dest,
         input logic [31:0] src, input logic [31:0] span,
         input logic [31:0] seed);
      return {5'd0, seed, span, src, dest, en, st, func};
   endfunction

   function automatic logic [143:0] load_item(input int st, input int en,
         input logic [31:0] dest, input logic [31:0] src,
         input logic [31:0] span);
      return pack_item(FUNC_LOAD, st[2:0], en[5:0], dest, src, span, $urandom);
   endfunction

   function automatic logic [143:0] xlate_item(input logic [31:0] seed);
      return pack_item(FUNC_XLATE, 3'($urandom), 6'($urandom), $urandom,
                       $urandom, $urandom, seed);
   endfunction

   function automatic logic [143:0] clear_item();
      return pack_item(FUNC_CLEAR, 3'($urandom), 6'($urandom), $urandom,
                       $urandom, $urandom, $urandom);
   endfunction

   // Receiver ready: random idling, or a long hold when asked.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_hold) rsp_tready <= 1'b0;
      else if (idle_enable) rsp_tready <= ($urandom_range(99) >= 29);
      else rsp_tready <= 1'b1;
   end

   // Result checker: compares each accepted result with the oldest
   // expectation.
   always @(posedge clock) begin
      remap_result_type exp_r;
      remap_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[64:0];
         if (exp_wr == exp_rd) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item %h", got);
         end else begin
            exp_r = exp_ring[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (got !== exp_r || rsp_tdata[71:65] !== 7'd0) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: loc exp %h got %h, min exp %h got %h, vld exp %b got %b",
                           exp_r.location, got.location, exp_r.min_location,
                           got.min_location, exp_r.min_valid, got.min_valid);
            end
         end
      end
   end

   // Picks a seed that often lands inside or at the edge of a loaded range.
   function automatic logic [31:0] pick_seed();
      int k;
      k = $urandom_range(NSLOT - 1);
      case ($urandom_range(4))
         0: return $urandom;
         1: return shadow_src[k];
         2: return shadow_src[k] + shadow_span[k] - 1;
         3: return shadow_src[k] + shadow_span[k];
         default: return shadow_src[k] + $urandom_range(255);
      endcase
   endfunction

   // Directed corners: extreme fields, every function, all special cases.
   task automatic test_directed();
      send_item(xlate_item('0));             // empty table passes value through
      send_item(xlate_item('1));             // all ones still sets min_valid
      send_item(load_item(0, 0, 32'h100, 32'h10, 32'h10));
      send_item(load_item(0, 63, '1, '1, '1)); // top slot, wraps on the add
      send_item(load_item(1, 0, 32'h5, 32'h0, 32'h0)); // zero span
      send_item(load_item(6, 63, 32'h0, 32'h110, 32'h8));
      send_item(pack_item(FUNC_LOAD, 3'd7, 6'd5, 32'h1, 32'h0, '1, '0)); // bad stage
      send_item(xlate_item(32'h10));
      send_item(xlate_item(32'h1f));
      send_item(xlate_item(32'h20));
      send_item(xlate_item(32'h0));
      send_item(xlate_item('1));
      send_item(xlate_item(32'hffff_fffe));
      send_item(pack_item(FUNC_UNUSED, '1, '1, '1, '1, '1, '1)); // unused code
      send_item(clear_item());
      send_item(xlate_item(32'h10));
      send_item(load_item(2, 10, '1, 32'h8000_0000, 32'h8000_0000));
      send_item(xlate_item('1));
      send_item(xlate_item(32'h8000_0000));
      send_item(clear_item());
   endtask

   // Ascending well-formed loads per stage, translates, clears and random items.
   task automatic test_random_tables(input int n_items);
      logic [31:0] base [NST];
      logic [31:0] sp;
      int st;
      for (int i = 0; i < NST; i++) base[i] = $urandom_range(4095);
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(19))
            0: begin
               send_item(clear_item());
               for (int j = 0; j < NST; j++) base[j] = $urandom_range(4095);
            end
            1, 2: send_item(pack_item(2'($urandom_range(3)), 3'($urandom),
                                      6'($urandom), $urandom, $urandom,
                                      $urandom, $urandom));
            3, 4, 5, 6, 7, 8: begin
               st = $urandom_range(NST - 1);
               sp = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 600);
               send_item(load_item(st, $urandom_range(NEN - 1),
                                   $urandom_range(6000), base[st], sp));
               base[st] = base[st] + sp + $urandom_range(50);
            end
            default: send_item(xlate_item(pick_seed()));
         endcase
      end
   endtask

   // Receiver holds off for a long stretch while loads keep coming.
   task automatic test_backpressure();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (300) @(negedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 12; i++)
            send_item(load_item($urandom_range(NST - 1), $urandom_range(NEN - 1),
                                $urandom, $urandom, $urandom));
      join
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_hold = 1'b0;
      idle_enable = 1'b0;
      mismatch_count = 0;
      failed = 1'b0;
      exp_wr = 0;
      exp_rd = 0;
      for (int i = 0; i < NSLOT; i++) begin
         shadow_dest[i] = '0;
         shadow_src[i] = '0;
         shadow_span[i] = '0;
         shadow_vld[i] = 1'b0;
      end
      shadow_min = '1;
      shadow_seen = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();           // no idling here
      idle_enable = 1'b1;
      test_backpressure();
      test_random_tables(650);
      idle_enable = 1'b0;        // a long stretch without idling
      test_random_tables(300);
      idle_enable = 1'b1;
      test_random_tables(330);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (exp_wr != exp_rd && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (NST * (NEN + 2) + 10) @(negedge clock);
      if (!failed && exp_wr == exp_rd) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/crrm_pkg.sv
rtl/core/crrm_cell.sv
rtl/core/cascaded_range_remap_min.sv
sim/tb.sv
